// File: design/sjs_pkg.sv
// Shared types and constants for the scan jump segmenter.
package sjs_pkg;

  localparam int RANGE_W   = 16;
  localparam int POS_W     = 16;
  localparam int LIMIT_W   = 15;
  localparam int START_W   = 10;
  localparam int POINTS_W  = 11;
  localparam int COUNT_W   = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Result queue geometry (depth is a power of two)
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RANGE      = 3'd0,
    CFG_MIN_RUN_POINTS = 3'd1,
    CFG_MAX_OBJECTS    = 3'd2,
    CFG_JUMP_THRESHOLD = 3'd3,
    CFG_X_LIMIT        = 3'd4,
    CFG_Y_LIMIT        = 3'd5
  } sjs_cfg_idx_t;

  // Register reset values
  localparam logic [RANGE_W-1:0]  RST_MIN_RANGE      = 16'd0;
  localparam logic [POINTS_W-1:0] RST_MIN_RUN_POINTS = 11'd1;
  localparam logic [COUNT_W-1:0]  RST_MAX_OBJECTS    = 8'd16;
  localparam logic [RANGE_W-1:0]  RST_JUMP_THRESHOLD = 16'd90;
  localparam logic [LIMIT_W-1:0]  RST_X_LIMIT        = 15'd1300;
  localparam logic [LIMIT_W-1:0]  RST_Y_LIMIT        = 15'd800;

  typedef struct packed {
    logic [RANGE_W-1:0]        range_mm;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic                      scan_end;
  } sjs_in_t;

  typedef struct packed {
    logic                  object_valid;
    logic [START_W-1:0]    start_index;
    logic [POINTS_W-1:0]   object_points;
    logic [COUNT_W-1:0]    objects_so_far;
    logic                  scan_done;
  } sjs_out_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  min_range;
    logic [POINTS_W-1:0] min_run_points;
    logic [COUNT_W-1:0]  max_objects;
    logic [RANGE_W-1:0]  jump_threshold;
    logic [LIMIT_W-1:0]  x_limit;
    logic [LIMIT_W-1:0]  y_limit;
  } sjs_cfg_t;

  // Up to two results written into the queue per item
  typedef struct packed {
    logic     push0;
    logic     push1;
    sjs_out_t res0;
    sjs_out_t res1;
  } sjs_push_t;

endpackage

// File: design/sjs_seg.sv
// Run tracking state and per-point segmentation logic.
module sjs_seg
  import sjs_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  sjs_in_t   item,
  input  sjs_cfg_t  cfg,
  output sjs_push_t push
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LEN_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (LEN_W > POINTS_W) ? LEN_W : POINTS_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

  logic               in_run_r, in_run_nxt;
  logic [IDX_W-1:0]   run_start_r, run_start_nxt;
  logic [LEN_W-1:0]   run_length_r, run_length_nxt;
  logic [RANGE_W-1:0] prev_range_r, prev_range_nxt;
  logic [IDX_W-1:0]   point_index_r, point_index_nxt;
  logic [COUNT_W-1:0] obj_count_r, obj_count_nxt;

  logic [POS_W-1:0]   abs_x, abs_y;
  logic [RANGE_W-1:0] step_mag;
  logic               pt_valid, last, jump, restart;
  logic               emit0, emit1;
  logic [IDX_W-1:0]   a_start;
  logic [LEN_W-1:0]   a_len;
  logic [COUNT_W-1:0] cnt1, cnt2;
  sjs_out_t           obj0, obj1, empty_res;

  // Point validity: magnitude of -32768 comes out as 32768 unsigned
  assign abs_x = item.pos_x[POS_W-1] ? (~item.pos_x + 16'd1) : item.pos_x;
  assign abs_y = item.pos_y[POS_W-1] ? (~item.pos_y + 16'd1) : item.pos_y;
  assign pt_valid = (item.range_mm >= cfg.min_range) &&
                    (abs_x <= {1'b0, cfg.x_limit}) &&
                    (abs_y <= {1'b0, cfg.y_limit});
  assign last = item.scan_end || (point_index_r == LAST_IDX);

  // Range step against the previous point of the run
  assign step_mag = (item.range_mm >= prev_range_r) ? (item.range_mm - prev_range_r)
                                                    : (prev_range_r - item.range_mm);
  assign jump    = pt_valid && in_run_r && (step_mag >= cfg.jump_threshold);
  assign restart = !in_run_r || jump;

  always_comb begin
    // First close: invalid point or jump ends the open run
    emit0 = (!pt_valid || jump) && in_run_r &&
            (CMP_W'(run_length_r) >= CMP_W'(cfg.min_run_points)) &&
            (obj_count_r < cfg.max_objects);
    cnt1 = obj_count_r + COUNT_W'(emit0);

    // Run as it stands after this point
    a_start = restart ? point_index_r : run_start_r;
    a_len   = restart ? LEN_W'(1) : (run_length_r + LEN_W'(1));

    // Second close: end of scan keeps the final point
    emit1 = last && pt_valid &&
            (CMP_W'(a_len) >= CMP_W'(cfg.min_run_points)) &&
            (cnt1 < cfg.max_objects);
    cnt2 = cnt1 + COUNT_W'(emit1);

    obj0.object_valid   = 1'b1;
    obj0.start_index    = START_W'(run_start_r);
    obj0.object_points  = POINTS_W'(run_length_r);
    obj0.objects_so_far = cnt1;
    obj0.scan_done      = 1'b0;

    obj1.object_valid   = 1'b1;
    obj1.start_index    = START_W'(a_start);
    obj1.object_points  = POINTS_W'(a_len);
    obj1.objects_so_far = cnt2;
    obj1.scan_done      = 1'b1;

    empty_res.object_valid   = 1'b0;
    empty_res.start_index    = '0;
    empty_res.object_points  = '0;
    empty_res.objects_so_far = cnt2;
    empty_res.scan_done      = 1'b1;

    // Pack results into queue slots, done mark on the last one
    push.push0 = step_en && (emit0 || last);
    push.push1 = step_en && emit0 && emit1;
    if (emit0) begin
      push.res0 = obj0;
      push.res0.scan_done = last && !emit1;
    end else if (emit1) begin
      push.res0 = obj1;
    end else begin
      push.res0 = empty_res;
    end
    push.res1 = obj1;

    // Next state
    if (last) begin
      in_run_nxt      = 1'b0;
      run_start_nxt   = '0;
      run_length_nxt  = '0;
      prev_range_nxt  = '0;
      point_index_nxt = '0;
      obj_count_nxt   = '0;
    end else begin
      in_run_nxt      = pt_valid;
      run_start_nxt   = pt_valid ? a_start : run_start_r;
      run_length_nxt  = pt_valid ? a_len : '0;
      prev_range_nxt  = pt_valid ? item.range_mm : prev_range_r;
      point_index_nxt = point_index_r + IDX_W'(1);
      obj_count_nxt   = cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r      <= 1'b0;
      run_start_r   <= '0;
      run_length_r  <= '0;
      prev_range_r  <= '0;
      point_index_r <= '0;
      obj_count_r   <= '0;
    end else if (step_en) begin
      in_run_r      <= in_run_nxt;
      run_start_r   <= run_start_nxt;
      run_length_r  <= run_length_nxt;
      prev_range_r  <= prev_range_nxt;
      point_index_r <= point_index_nxt;
      obj_count_r   <= obj_count_nxt;
    end
  end

endmodule

// File: design/sjs_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
module sjs_fifo
  import sjs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sjs_push_t         push,
  output logic              out_valid,
  input  logic              out_stall,
  output sjs_out_t          out_data,
  output logic [QCNT_W-1:0] level
);

  sjs_out_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                pop;
  logic [QPTR_W-1:0]   wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign level     = cnt_r;
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.push0) + QPTR_W'(push.push1);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.push0) + QCNT_W'(push.push1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

// File: design/scan_jump_segmenter.sv
// Top level of the scan jump segmenter.
// Takes one scan point per clock cycle while in_stall is low. A point is
// registered on entry, classified against the run state in one pass, and its
// results (none, one, or two when a jump lands on the final point) go into an
// eight-entry result queue that drains one result per cycle while out_stall
// is low. in_stall rises when the queue plus the point in the entry register
// could not absorb two more results; while out_stall stays low and each point
// yields at most one result, the block sustains one point per cycle.
// Configuration writes take effect at the next edge and are meant for idle
// periods between scans.
module scan_jump_segmenter
  import sjs_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sjs_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sjs_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  sjs_cfg_t          cfg_r;
  logic              stg_v_r;
  sjs_in_t           stg_r;
  logic              in_acc;
  logic [QCNT_W-1:0] level;
  logic [QCNT_W:0]   need;
  sjs_push_t         push;

  // Back-pressure from queue room
  assign need     = (QCNT_W + 1)'(level) + (QCNT_W + 1)'({stg_v_r, 1'b0});
  assign in_stall = (need > (QCNT_W + 1)'(QDEPTH - 2));
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range      <= RST_MIN_RANGE;
      cfg_r.min_run_points <= RST_MIN_RUN_POINTS;
      cfg_r.max_objects    <= RST_MAX_OBJECTS;
      cfg_r.jump_threshold <= RST_JUMP_THRESHOLD;
      cfg_r.x_limit        <= RST_X_LIMIT;
      cfg_r.y_limit        <= RST_Y_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RANGE:      cfg_r.min_range      <= cfg_wdata;
        CFG_MIN_RUN_POINTS: cfg_r.min_run_points <= cfg_wdata[POINTS_W-1:0];
        CFG_MAX_OBJECTS:    cfg_r.max_objects    <= cfg_wdata[COUNT_W-1:0];
        CFG_JUMP_THRESHOLD: cfg_r.jump_threshold <= cfg_wdata;
        CFG_X_LIMIT:        cfg_r.x_limit        <= cfg_wdata[LIMIT_W-1:0];
        CFG_Y_LIMIT:        cfg_r.y_limit        <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r <= in_data;
    end
  end

  sjs_seg #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seg (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(stg_v_r),
    .item   (stg_r),
    .cfg    (cfg_r),
    .push   (push)
  );

  sjs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .level    (level)
  );

endmodule

// File: design/sjs_checker.sv
// Port-level checks for the scan jump segmenter, bound to the top level.
module sjs_checker
  import sjs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input sjs_out_t out_data
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // An empty result only marks the end of a scan
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.object_valid |->
      out_data.scan_done && (out_data.object_points == '0) &&
      (out_data.start_index == '0))
    else $error("malformed empty result");

  // An object always counts itself
  a_obj_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.object_valid |->
      (out_data.objects_so_far != '0) && (out_data.object_points != '0))
    else $error("object without count or points");

endmodule

bind scan_jump_segmenter sjs_checker u_sjs_checker (.*);
